/* rtl/mld_pkg.sv */
// Package for the Morse light decoder: shared types, register codes and the
// A-Z/0-9 code table with its character map. Used by every module in rtl/.
package mld_pkg;

	localparam int CODE_COUNT = 36;
	localparam int FIFO_DEPTH = 4;

	localparam logic [6:0] CH_SPACE   = 7'd32;
	localparam logic [6:0] CH_NEWLINE = 7'd10;

	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_DOT_MIN   = 3'd1,
		REG_DASH_MIN  = 3'd2,
		REG_LETTER    = 3'd3,
		REG_WORD      = 3'd4,
		REG_LINE      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] threshold;
		logic [23:0] dot_min_us;
		logic [23:0] dash_min_us;
		logic [23:0] letter_gap_us;
		logic [23:0] word_gap_us;
		logic [23:0] line_gap_us;
	} cfg_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic [1:0] cnt;
		entry_t     w0;
		entry_t     w1;
	} push_t;

	// Symbol k of a letter sits at bit k, dot is 0 and dash is 1.
	localparam logic [2:0] CODE_LEN [CODE_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
		3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd5
	};

	localparam logic [4:0] CODE_BITS [CODE_COUNT] = '{
		5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0,
		5'd14, 5'd5, 5'd2, 5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2,
		5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
		5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3,
		5'd7, 5'd15
	};

	function automatic logic [6:0] code_char(input int unsigned i);
		if (i < 26) begin
			return 7'(65 + i);
		end
		return 7'(48 + i - 26);
	endfunction

endpackage

/* rtl/morse_light_decoder_top.sv */
// Top level of the Morse light decoder: configuration registers, decoder core
// and result queue. Depends on mld_pkg, mld_core and mld_fifo.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    sample, time_us
//   out      output     out_valid / out_stall  char_code, last
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input word is taken per cycle while in_stall is low; its results enter
// the queue at the same edge, and each is offered on the output at the queue head.
// in_stall rises when the four-entry result queue has less than two free slots.
// cfg_ready is always high; reset loads the default register values.
module morse_light_decoder_top import mld_pkg::*; #(
	parameter int MAX_SYMBOLS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] sample,
	input  logic [31:0] time_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  char_code,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t   cfg_q;
	push_t  push;
	entry_t head;
	logic   accept, pop, no_room;

	assign cfg_ready = 1'b1;
	assign in_stall  = no_room;
	assign accept    = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;
	assign char_code = head.char_code;
	assign last      = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= 12'd0;
			cfg_q.dot_min_us    <= 24'd10000;
			cfg_q.dash_min_us   <= 24'd110000;
			cfg_q.letter_gap_us <= 24'd110000;
			cfg_q.word_gap_us   <= 24'd310000;
			cfg_q.line_gap_us   <= 24'd660000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THRESHOLD: cfg_q.threshold     <= cfg_data[11:0];
				REG_DOT_MIN:   cfg_q.dot_min_us    <= cfg_data;
				REG_DASH_MIN:  cfg_q.dash_min_us   <= cfg_data;
				REG_LETTER:    cfg_q.letter_gap_us <= cfg_data;
				REG_WORD:      cfg_q.word_gap_us   <= cfg_data;
				REG_LINE:      cfg_q.line_gap_us   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mld_core #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.time_us(time_us),
		.cfg    (cfg_q),
		.push   (push)
	);

	mld_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.head    (head),
		.nonempty(out_valid),
		.no_room (no_room)
	);

endmodule

/* rtl/mld_match.sv */
// Letter matcher: compares the symbol buffer with every table entry at once.
// Depends on mld_pkg for the code table.
module mld_match import mld_pkg::*; #(
	parameter int MAX_SYMBOLS = 9,
	parameter int CW = $clog2(MAX_SYMBOLS + 1)
) (
	input  logic [CW-1:0]          count,
	input  logic [MAX_SYMBOLS-1:0] bits,
	output logic                   hit,
	output logic [6:0]             char_code
);

	always_comb begin
		hit = 1'b0;
		char_code = '0;
		for (int i = 0; i < CODE_COUNT; i++) begin
			if (count == CW'(CODE_LEN[i]) && bits == MAX_SYMBOLS'(CODE_BITS[i])) begin
				hit = 1'b1;
				char_code = char_code | code_char(i);
			end
		end
	end

endmodule

/* rtl/mld_core.sv */
// Decoder state: light level, edge timing, symbol buffer, overflow and pause
// flags, updated once per accepted word. Depends on mld_pkg and mld_match.
module mld_core import mld_pkg::*; #(
	parameter int MAX_SYMBOLS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [11:0] sample,
	input  logic [31:0] time_us,
	input  cfg_t        cfg,
	output push_t       push
);

	localparam int CW = $clog2(MAX_SYMBOLS + 1);

	logic                   on_q;
	logic                   paused_q;
	logic [31:0]            edge_q;
	logic [CW-1:0]          cnt_q;
	logic [MAX_SYMBOLS-1:0] bits_q;
	logic                   ovf_q;

	logic [31:0] gap;
	logic        line_hit, light, rise, fall, flush, tail, emit_char;
	logic        is_dash, is_sym, hit;
	logic [6:0]  match_ch, tail_ch;

	mld_match #(.MAX_SYMBOLS(MAX_SYMBOLS), .CW(CW)) u_match (
		.count    (cnt_q),
		.bits     (bits_q),
		.hit      (hit),
		.char_code(match_ch)
	);

	always_comb begin
		gap       = time_us - edge_q;
		line_hit  = !paused_q && (gap > {8'd0, cfg.line_gap_us});
		light     = sample > cfg.threshold;
		rise      = !line_hit && light && !on_q;
		fall      = !line_hit && !light && on_q;
		flush     = line_hit || (rise && !paused_q && (gap > {8'd0, cfg.letter_gap_us}));
		tail      = line_hit || (rise && !paused_q && (gap > {8'd0, cfg.word_gap_us}));
		emit_char = flush && hit && !ovf_q;
		is_dash   = gap > {8'd0, cfg.dash_min_us};
		is_sym    = is_dash || (gap > {8'd0, cfg.dot_min_us});
		tail_ch   = line_hit ? CH_NEWLINE : CH_SPACE;

		push.cnt = accept ? ({1'b0, emit_char} + {1'b0, tail}) : 2'd0;
		push.w1  = '{char_code: tail_ch, last: 1'b1};
		if (emit_char) begin
			push.w0 = '{char_code: match_ch, last: !tail};
		end else begin
			push.w0 = '{char_code: tail_ch, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q     <= 1'b0;
			paused_q <= 1'b1;
			edge_q   <= '0;
			cnt_q    <= '0;
			bits_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			if (flush) begin
				cnt_q  <= '0;
				bits_q <= '0;
				ovf_q  <= 1'b0;
			end
			if (line_hit) begin
				paused_q <= 1'b1;
			end else if (rise) begin
				on_q     <= 1'b1;
				paused_q <= 1'b0;
				edge_q   <= time_us;
			end else if (fall) begin
				on_q   <= 1'b0;
				edge_q <= time_us;
				if (is_sym) begin
					if (cnt_q >= CW'(MAX_SYMBOLS)) begin
						ovf_q <= 1'b1;
					end else begin
						bits_q <= bits_q | (MAX_SYMBOLS'(is_dash) << cnt_q);
						cnt_q  <= cnt_q + CW'(1);
					end
				end
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SYMBOLS))
		else $error("symbol count beyond buffer size");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CW'(MAX_SYMBOLS))
		else $error("overflow flagged with buffer not full");

endmodule

/* rtl/mld_fifo.sv */
// Result queue: takes up to two words per cycle from the decoder core and
// hands out one per cycle while popped. Depends on mld_pkg for the entry types.
module mld_fifo import mld_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output entry_t head,
	output logic   nonempty,
	output logic   no_room
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	entry_t        mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign head     = mem_q[rd_q];
	assign nonempty = cnt_q != '0;
	assign no_room  = cnt_q > NW'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.w0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[PW'(wr_q + PW'(1))] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push.cnt);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + NW'(push.cnt) - NW'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (cnt_q <= NW'(FIFO_DEPTH - 2)))
		else $error("push into result queue without room for two words");

endmodule
